// File: sv/kvlt_pkg.sv
// ----------------------------------------------------------------------------
// kvlt_pkg
// Shared constants, record codes and the command type passed from the
// classifying front end to the record emitter of the line tokenizer.
// ----------------------------------------------------------------------------
package kvlt_pkg;

  // Whitespace store depth and the widths derived from it
  localparam int HOLD_DEPTH = 32;
  localparam int IDX_W      = $clog2(HOLD_DEPTH);
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

  // Command queue depth and the widths derived from it
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  // Record kinds
  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  // One command: release ws_cnt held whitespace bytes (bit set means tab),
  // then emit one closing record that carries the last flag
  typedef struct packed {
    logic [HOLD_DEPTH-1:0] ws_vec;
    logic [CNT_W-1:0]      ws_cnt;
    logic [1:0]            kind;
    logic [7:0]            data;
    logic                  ovf;
    logic [31:0]           line;
  } cmd_t;

endpackage

// File: sv/key_value_line_tokenizer_core.sv
// Path: each record is registered in the command queue, then in the output register.
// Throughput: one byte per cycle while each byte causes at most one record and out_ready
//   stays high; a byte that releases n held whitespace bytes occupies the record emitter
//   for n + 1 records, as the output register moves one record per cycle. A 2-entry command queue decouples.
// Reset: synchronous, clears phase, line count, queue and output valid; the whitespace
//   store is not cleared.
// ----------------------------------------------------------------------------
// key_value_line_tokenizer_core
// Streaming tokenizer of "key value" text lines into key, value and pair-end
// records tagged with the line number.
// ----------------------------------------------------------------------------
module key_value_line_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [31:0] line_number,
  output logic        last,
  output logic        ws_overflow
);

  kvlt_pkg::cmd_t wr_cmd;
  kvlt_pkg::cmd_t head;
  logic           push, room, pop, head_valid;

  assign in_ready = room;

  // Classify incoming bytes
  kvlt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .room     (room),
    .push     (push),
    .cmd      (wr_cmd)
  );

  // Buffer commands
  kvlt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_cmd     (wr_cmd),
    .room       (room),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Emit records
  kvlt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .out_byte    (out_byte),
    .line_number (line_number),
    .last        (last),
    .ws_overflow (ws_overflow)
  );

`ifndef SYNTHESIS
  // Pair end carries a zero byte and closes its byte's records
  a_end_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == kvlt_pkg::KIND_END) |-> (out_byte == 8'h00) && last)
    else $error("pair end record malformed");

  // Overflow is only reported on a pair end
  a_ovf_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && ws_overflow |-> (kind == kvlt_pkg::KIND_END))
    else $error("whitespace overflow outside pair end");

  // Key bytes never come with released whitespace
  a_key_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == kvlt_pkg::KIND_KEY) |-> last)
    else $error("key record not last of its byte");

  // Released whitespace is always followed by a further record of the same line
  a_run_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && (line_number == $past(line_number)))
    else $error("whitespace run broken");
`endif

endmodule

// File: sv/kvlt_front.sv
// ----------------------------------------------------------------------------
// kvlt_front
// Accepts text bytes, tracks the line phase, escapes and held whitespace,
// and pushes at most one command per byte into the command queue.
// ----------------------------------------------------------------------------
module kvlt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               room,
  output logic               push,
  output kvlt_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_KEY,
    PH_GAP,
    PH_VALUE,
    PH_IGNORE
  } phase_t;

  phase_t                          phase, phase_next;
  logic                            prev_bs, prev_bs_next;
  logic                            solid_bs, solid_bs_next;
  logic [kvlt_pkg::CNT_W-1:0]      held_count, held_count_next;
  logic                            overflow_seen, overflow_seen_next;
  logic [31:0]                     line_count, line_count_next;
  logic [kvlt_pkg::HOLD_DEPTH-1:0] held;
  logic                            held_wr;

  logic accept;
  logic is_ws, is_end, is_bs, is_hash, is_lf;
  logic push_c;

  assign accept  = in_valid && room;
  assign is_ws   = (in_byte == kvlt_pkg::CH_SPACE) || (in_byte == kvlt_pkg::CH_TAB);
  assign is_lf   = (in_byte == kvlt_pkg::CH_LF);
  assign is_end  = is_lf || (in_byte == kvlt_pkg::CH_NUL);
  assign is_bs   = (in_byte == kvlt_pkg::CH_BSL);
  assign is_hash = (in_byte == kvlt_pkg::CH_HASH);

  // Classify the byte and work out the next state and command
  always_comb begin
    phase_next         = phase;
    prev_bs_next       = prev_bs;
    solid_bs_next      = solid_bs;
    held_count_next    = held_count;
    overflow_seen_next = overflow_seen;
    line_count_next    = line_count;
    held_wr            = 1'b0;
    push_c             = 1'b0;
    cmd.ws_vec         = held;
    cmd.ws_cnt         = '0;
    cmd.kind           = kvlt_pkg::KIND_KEY;
    cmd.data           = in_byte;
    cmd.ovf            = 1'b0;
    cmd.line           = line_count + 32'd1;

    case (phase)
      PH_LEAD: begin
        if (is_lf) begin
          line_count_next = line_count + 32'd1;
        end else if (is_ws) begin
          // keep skipping leading whitespace
        end else if (is_hash || (in_byte == kvlt_pkg::CH_NUL)) begin
          phase_next = PH_IGNORE;
        end else begin
          push_c       = 1'b1;
          prev_bs_next = is_bs;
          phase_next   = PH_KEY;
        end
      end
      PH_KEY: begin
        if (is_end || (is_hash && !prev_bs)) begin
          push_c = 1'b1;
        end else if (is_ws && !prev_bs) begin
          prev_bs_next = 1'b0;
          phase_next   = PH_GAP;
        end else begin
          push_c       = 1'b1;
          prev_bs_next = is_bs;
        end
      end
      PH_GAP: begin
        if (is_end || is_hash) begin
          push_c = 1'b1;
        end else if (!is_ws) begin
          push_c             = 1'b1;
          cmd.kind           = kvlt_pkg::KIND_VALUE;
          prev_bs_next       = is_bs;
          solid_bs_next      = is_bs;
          held_count_next    = '0;
          overflow_seen_next = 1'b0;
          phase_next         = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (is_end || (is_hash && !prev_bs)) begin
          push_c = 1'b1;
          // a final backslash keeps the first held whitespace byte
          if (solid_bs && (held_count != '0)) begin
            cmd.ws_cnt = kvlt_pkg::CNT_W'(1);
          end
        end else if (is_ws) begin
          if (held_count < kvlt_pkg::CNT_W'(kvlt_pkg::HOLD_DEPTH)) begin
            held_wr         = 1'b1;
            held_count_next = held_count + kvlt_pkg::CNT_W'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
          prev_bs_next = 1'b0;
        end else begin
          push_c          = 1'b1;
          cmd.kind        = kvlt_pkg::KIND_VALUE;
          cmd.ws_cnt      = held_count;
          held_count_next = '0;
          prev_bs_next    = is_bs;
          solid_bs_next   = is_bs;
        end
      end
      default: begin
        if (is_lf) begin
          line_count_next = line_count + 32'd1;
          phase_next      = PH_LEAD;
        end
      end
    endcase

    // Pair end closes the line content
    if (push_c && ((phase == PH_KEY && (is_end || (is_hash && !prev_bs))) ||
                   (phase == PH_GAP && (is_end || is_hash)) ||
                   (phase == PH_VALUE && (is_end || (is_hash && !prev_bs))))) begin
      cmd.kind           = kvlt_pkg::KIND_END;
      cmd.data           = '0;
      cmd.ovf            = overflow_seen;
      prev_bs_next       = 1'b0;
      solid_bs_next      = 1'b0;
      held_count_next    = '0;
      overflow_seen_next = 1'b0;
      if (is_lf) begin
        line_count_next = line_count + 32'd1;
        phase_next      = PH_LEAD;
      end else begin
        phase_next = PH_IGNORE;
      end
    end
  end

  assign push = accept && push_c;

  // Hold state and advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      prev_bs       <= 1'b0;
      solid_bs      <= 1'b0;
      held_count    <= '0;
      overflow_seen <= 1'b0;
      line_count    <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      prev_bs       <= prev_bs_next;
      solid_bs      <= solid_bs_next;
      held_count    <= held_count_next;
      overflow_seen <= overflow_seen_next;
      line_count    <= line_count_next;
    end
  end

  // Whitespace store: bit set means tab
  always_ff @(posedge clk) begin
    if (accept && held_wr) begin
      held[held_count[kvlt_pkg::IDX_W-1:0]] <= (in_byte == kvlt_pkg::CH_TAB);
    end
  end

endmodule

// File: sv/kvlt_queue.sv
// ----------------------------------------------------------------------------
// kvlt_queue
// Short command FIFO between the front end and the record emitter.
// ----------------------------------------------------------------------------
module kvlt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kvlt_pkg::cmd_t wr_cmd,
  output logic           room,
  input  logic           pop,
  output logic           head_valid,
  output kvlt_pkg::cmd_t head
);

  kvlt_pkg::cmd_t                entries [kvlt_pkg::Q_DEPTH];
  logic [kvlt_pkg::Q_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [kvlt_pkg::Q_CNT_W-1:0]  count;

  assign room       = (count != kvlt_pkg::Q_CNT_W'(kvlt_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == kvlt_pkg::Q_PTR_W'(kvlt_pkg::Q_DEPTH - 1)) ?
                  '0 : wr_ptr + kvlt_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == kvlt_pkg::Q_PTR_W'(kvlt_pkg::Q_DEPTH - 1)) ?
                  '0 : rd_ptr + kvlt_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + kvlt_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - kvlt_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

// File: sv/kvlt_back.sv
// ----------------------------------------------------------------------------
// kvlt_back
// Record emitter: plays out the held whitespace of each command one byte a
// cycle while the output is taken, then the closing record, through a registered output stage.
// ----------------------------------------------------------------------------
module kvlt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  kvlt_pkg::cmd_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     kind,
  output logic [7:0]     out_byte,
  output logic [31:0]    line_number,
  output logic           last,
  output logic           ws_overflow
);

  logic [kvlt_pkg::CNT_W-1:0] idx;
  logic                       load;
  logic                       in_run;

  assign load   = !out_valid || out_ready;
  assign in_run = (idx < head.ws_cnt);
  assign pop    = load && head_valid && !in_run;

  // Load the output register when it is empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        if (in_run) begin
          idx <= idx + kvlt_pkg::CNT_W'(1);
        end else begin
          idx <= '0;
        end
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      line_number <= head.line;
      if (in_run) begin
        kind        <= kvlt_pkg::KIND_VALUE;
        out_byte    <= head.ws_vec[idx[kvlt_pkg::IDX_W-1:0]] ?
                       kvlt_pkg::CH_TAB : kvlt_pkg::CH_SPACE;
        last        <= 1'b0;
        ws_overflow <= 1'b0;
      end else begin
        kind        <= head.kind;
        out_byte    <= head.data;
        last        <= 1'b1;
        ws_overflow <= head.ovf;
      end
    end
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds text lines into the key/value line tokenizer and checks every key,
// value and pair-end record against a byte-level predictor of the tokenizer.
// A short directed run is followed by random lines: blank, comment, key only,
// key and value with escapes and whitespace runs (some past the store depth),
// NUL-ended lines and noise. Both sides idle at random and the receiver holds
// off once for a long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIRECTED_BYTES = 27;
  localparam int RANDOM_BYTES   = 253;
  localparam int IDLE_LIMIT     = 1000;
  localparam int TAIL_CYCLES    = 20;
  localparam int HOLD_OFF       = 80;
  localparam int HOLD_OFF_AT    = 120;

  // One output record
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] line;
    logic        last;
    logic        ovf;
  } token_rec_t;

  // Scanner position within a line
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_KEY   = 3'd1,
    PH_GAP   = 3'd2,
    PH_VALUE = 3'd3,
    PH_SKIP  = 3'd4
  } scan_phase_t;

  // --------------------------------------------------------------------------
  // Predictor of the records each byte causes, and the store of those
  // records still to arrive
  // --------------------------------------------------------------------------
  class pair_record_predictor;
    scan_phase_t                   phase;
    bit                            prev_bs;
    bit                            solid_bs;
    bit [kvlt_pkg::HOLD_DEPTH-1:0] held_tab;
    int                            held_n;
    bit                            ovf_seen;
    logic [31:0]                   lines;
    token_rec_t                    fresh[$];
    token_rec_t                    expected_records[$];
    int                            accepted;
    int                            errors;

    function new();
      phase    = PH_LEAD;
      prev_bs  = 1'b0;
      solid_bs = 1'b0;
      held_tab = '0;
      held_n   = 0;
      ovf_seen = 1'b0;
      lines    = '0;
      accepted = 0;
      errors   = 0;
    endfunction

    function void emit(logic [1:0] k, logic [7:0] d, logic o);
      token_rec_t r;
      r = '{k, d, lines + 32'd1, 1'b0, o};
      fresh.push_back(r);
    endfunction

    // Close the pair and move on to the next line or to the ignored tail
    function void close_pair(logic [7:0] b);
      emit(kvlt_pkg::KIND_END, kvlt_pkg::CH_NUL, ovf_seen);
      if (b == kvlt_pkg::CH_LF) begin
        lines = lines + 32'd1;
        phase = PH_LEAD;
      end else begin
        phase = PH_SKIP;
      end
      prev_bs  = 1'b0;
      solid_bs = 1'b0;
      held_n   = 0;
      ovf_seen = 1'b0;
    endfunction

    // Note an accepted request and queue the records it causes
    function void take_byte(logic [7:0] b);
      bit         ws;
      bit         stop;
      bit         bsl;
      token_rec_t r;
      ws   = (b == kvlt_pkg::CH_SPACE) || (b == kvlt_pkg::CH_TAB);
      stop = (b == kvlt_pkg::CH_LF) || (b == kvlt_pkg::CH_NUL);
      bsl  = (b == kvlt_pkg::CH_BSL);
      fresh.delete();
      accepted++;
      case (phase)
        PH_LEAD: begin
          if (b == kvlt_pkg::CH_LF) begin
            lines = lines + 32'd1;
          end else if (ws) begin
            // skip leading whitespace
          end else if (b == kvlt_pkg::CH_HASH || b == kvlt_pkg::CH_NUL) begin
            phase = PH_SKIP;
          end else begin
            emit(kvlt_pkg::KIND_KEY, b, 1'b0);
            prev_bs = bsl;
            phase   = PH_KEY;
          end
        end
        PH_KEY: begin
          if (stop || (b == kvlt_pkg::CH_HASH && !prev_bs)) begin
            close_pair(b);
          end else if (ws && !prev_bs) begin
            prev_bs = 1'b0;
            phase   = PH_GAP;
          end else begin
            emit(kvlt_pkg::KIND_KEY, b, 1'b0);
            prev_bs = bsl;
          end
        end
        PH_GAP: begin
          if (stop || b == kvlt_pkg::CH_HASH) begin
            close_pair(b);
          end else if (!ws) begin
            emit(kvlt_pkg::KIND_VALUE, b, 1'b0);
            prev_bs  = bsl;
            solid_bs = bsl;
            held_n   = 0;
            ovf_seen = 1'b0;
            phase    = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (stop || (b == kvlt_pkg::CH_HASH && !prev_bs)) begin
            // a final backslash keeps the first held whitespace byte
            if (solid_bs && held_n > 0)
              emit(kvlt_pkg::KIND_VALUE,
                   held_tab[0] ? kvlt_pkg::CH_TAB : kvlt_pkg::CH_SPACE, 1'b0);
            close_pair(b);
          end else if (ws) begin
            // hold whitespace; drop what does not fit and flag it
            if (held_n < kvlt_pkg::HOLD_DEPTH) begin
              held_tab[held_n] = (b == kvlt_pkg::CH_TAB);
              held_n++;
            end else begin
              ovf_seen = 1'b1;
            end
            prev_bs = 1'b0;
          end else begin
            for (int i = 0; i < held_n; i++)
              emit(kvlt_pkg::KIND_VALUE,
                   held_tab[i] ? kvlt_pkg::CH_TAB : kvlt_pkg::CH_SPACE, 1'b0);
            held_n = 0;
            emit(kvlt_pkg::KIND_VALUE, b, 1'b0);
            prev_bs  = bsl;
            solid_bs = bsl;
          end
        end
        default: begin
          if (b == kvlt_pkg::CH_LF) begin
            lines = lines + 32'd1;
            phase = PH_LEAD;
          end
        end
      endcase
      foreach (fresh[i]) begin
        r = fresh[i];
        r.last = (i == fresh.size() - 1);
        expected_records.push_back(r);
      end
    endfunction

    // Compare an accepted record with the oldest one expected
    function void match_record(logic [1:0] k, logic [7:0] d, logic [31:0] ln,
                               logic lst, logic o);
      token_rec_t e;
      if (expected_records.size() == 0) begin
        $error("unexpected record: kind %0d byte %0h line %0d", k, d, ln);
        errors++;
        return;
      end
      e = expected_records.pop_front();
      if (k !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, k);
        errors++;
      end
      if (d !== e.data) begin
        $error("out_byte: expected %0h, got %0h", e.data, d);
        errors++;
      end
      if (ln !== e.line) begin
        $error("line_number: expected %0d, got %0d", e.line, ln);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, lst);
        errors++;
      end
      if (o !== e.ovf) begin
        $error("ws_overflow: expected %0d, got %0d", e.ovf, o);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [31:0] line_number;
  logic        last;
  logic        ws_overflow;

  key_value_line_tokenizer_core uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .out_byte    (out_byte),
    .line_number (line_number),
    .last        (last),
    .ws_overflow (ws_overflow)
  );

  pair_record_predictor model;
  logic [7:0]           text[$];

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Text generation
  // --------------------------------------------------------------------------
  function automatic logic [7:0] solid_char();
    logic [7:0] c;
    do
      c = 8'($urandom_range(1, 255));
    while (c == kvlt_pkg::CH_TAB || c == kvlt_pkg::CH_LF || c == kvlt_pkg::CH_SPACE ||
           c == kvlt_pkg::CH_HASH || c == kvlt_pkg::CH_BSL);
    return c;
  endfunction

  function automatic void put_ws(int n);
    repeat (n) text.push_back($urandom_range(0, 1) ? kvlt_pkg::CH_TAB : kvlt_pkg::CH_SPACE);
  endfunction

  // Any bytes but newline
  function automatic void put_junk(int n);
    logic [7:0] c;
    repeat (n) begin
      do
        c = 8'($urandom_range(0, 255));
      while (c == kvlt_pkg::CH_LF);
      text.push_back(c);
    end
  endfunction

  // Word of solid bytes with the odd escape mixed in
  function automatic void put_word(int n);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        text.push_back(kvlt_pkg::CH_BSL);
        case ($urandom_range(0, 4))
          0:       text.push_back(kvlt_pkg::CH_SPACE);
          1:       text.push_back(kvlt_pkg::CH_TAB);
          2:       text.push_back(kvlt_pkg::CH_HASH);
          3:       text.push_back(kvlt_pkg::CH_BSL);
          default: text.push_back(solid_char());
        endcase
      end else begin
        text.push_back(solid_char());
      end
    end
  endfunction

  // End the line plainly, with a comment or with a NUL and ignored bytes
  function automatic void put_end();
    case ($urandom_range(0, 6))
      0: begin
        text.push_back(kvlt_pkg::CH_HASH);
        put_junk($urandom_range(0, 4));
      end
      1: begin
        text.push_back(kvlt_pkg::CH_NUL);
        put_junk($urandom_range(0, 4));
      end
      default: ;
    endcase
    text.push_back(kvlt_pkg::CH_LF);
  endfunction

  function automatic int long_run();
    case ($urandom_range(0, 3))
      0:       return kvlt_pkg::HOLD_DEPTH - 1;
      1:       return kvlt_pkg::HOLD_DEPTH;
      2:       return kvlt_pkg::HOLD_DEPTH + 1;
      default: return $urandom_range(kvlt_pkg::HOLD_DEPTH + 2, kvlt_pkg::HOLD_DEPTH + 8);
    endcase
  endfunction

  function automatic void put_line(bit force_long);
    int sel;
    int segs;
    bit long_gap;
    bit end_bsl;
    sel = force_long ? 3 : $urandom_range(0, 9);
    if ($urandom_range(0, 2) == 0) put_ws($urandom_range(1, 3));
    case (sel)
      0: text.push_back(kvlt_pkg::CH_LF);
      1: begin
        text.push_back(kvlt_pkg::CH_HASH);
        put_junk($urandom_range(0, 6));
        text.push_back(kvlt_pkg::CH_LF);
      end
      2: begin
        put_word($urandom_range(1, 5));
        if ($urandom_range(0, 1) == 0) put_ws($urandom_range(1, 3));
        put_end();
      end
      8: begin
        put_junk($urandom_range(3, 10));
        text.push_back(kvlt_pkg::CH_LF);
      end
      9: begin
        put_word($urandom_range(1, 4));
        text.push_back(kvlt_pkg::CH_NUL);
        put_junk($urandom_range(0, 4));
        text.push_back(kvlt_pkg::CH_LF);
      end
      default: begin
        long_gap = force_long || ($urandom_range(0, 7) == 0);
        segs     = force_long ? 2 : $urandom_range(1, 3);
        put_word($urandom_range(1, 5));
        put_ws($urandom_range(1, 3));
        for (int s = 0; s < segs; s++) begin
          put_word($urandom_range(1, 4));
          if (s < segs - 1) begin
            if (long_gap && s == 0) put_ws(force_long ? kvlt_pkg::HOLD_DEPTH + 4 : long_run());
            else                    put_ws($urandom_range(1, 4));
          end
        end
        // trailing whitespace, sometimes behind a final backslash
        end_bsl = ($urandom_range(0, 3) == 0);
        if (end_bsl) text.push_back(kvlt_pkg::CH_BSL);
        if (long_gap && segs == 1) put_ws(long_run());
        else                       put_ws($urandom_range(end_bsl ? 1 : 0, 3));
        put_end();
      end
    endcase
  endfunction

  function automatic void load_text();
    logic [7:0] directed[DIRECTED_BYTES];
    directed = '{
      // empty line
      kvlt_pkg::CH_LF,
      // comment after indent
      kvlt_pkg::CH_TAB, kvlt_pkg::CH_HASH, kvlt_pkg::CH_LF,
      // NUL at line start
      kvlt_pkg::CH_NUL, 8'hFF, kvlt_pkg::CH_LF,
      // escaped hash and space in key
      "k", kvlt_pkg::CH_BSL, kvlt_pkg::CH_HASH, kvlt_pkg::CH_BSL, kvlt_pkg::CH_SPACE,
      // value ends in backslash
      kvlt_pkg::CH_SPACE, "v", kvlt_pkg::CH_BSL, kvlt_pkg::CH_SPACE, kvlt_pkg::CH_TAB,
      // comment after held whitespace
      kvlt_pkg::CH_HASH, kvlt_pkg::CH_LF,
      // key only, NUL ends content
      "x", kvlt_pkg::CH_NUL, "q", kvlt_pkg::CH_LF,
      // hash in the gap
      "y", kvlt_pkg::CH_SPACE, kvlt_pkg::CH_HASH, kvlt_pkg::CH_LF
    };
    foreach (directed[i]) text.push_back(directed[i]);
    put_line(1'b1);
    while (text.size() < DIRECTED_BYTES + RANDOM_BYTES) put_line(1'b0);
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // Draw an idle count, with occasional stretches of no idling
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 30);
    return $urandom_range(0, 9);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model.take_byte(b);
  endtask

  // Take records forever, with one long hold-off once traffic is flowing
  task automatic drain_records();
    int stall;
    int calm;
    bit held_off;
    calm     = 0;
    held_off = 1'b0;
    forever begin
      stall = draw_wait(calm);
      if (!held_off && model.accepted >= HOLD_OFF_AT) begin
        stall    = HOLD_OFF;
        held_off = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      model.match_record(kind, out_byte, line_number, last, ws_overflow);
    end
  endtask

  // --------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else                                                    idle++;
    end
    $display("testbench: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : run
    int calm;
    calm  = 0;
    model = new();
    load_text();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_records();
    join_none
    foreach (text[i]) send_byte(text[i], draw_wait(calm));
    in_valid <= 1'b0;
    // drain, then let any byte still in flight show up
    while (model.expected_records.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (model.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/kvlt_pkg.sv
sv/kvlt_front.sv
sv/kvlt_queue.sv
sv/kvlt_back.sv
sv/key_value_line_tokenizer_core.sv
bench/testbench.sv
